>>> hw/rtl/ppms_pkg.sv
// Package for the peak picker with minimum separation.
// Holds the sample and index widths, the payload structs and register codes.
// No dependencies.
`default_nettype none

package ppms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 16;
  localparam int SEP_W    = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // register index, taken from the word address
  localparam logic REG_MIN_SEPARATION = 1'b0;

  localparam logic [SEP_W-1:0] MIN_SEP_RESET = 16'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [INDEX_W-1:0]         index_t;
  typedef logic [SEP_W-1:0]           sep_t;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } in_item_t;

  typedef struct packed {
    index_t  peak_index;
    sample_t peak_value;
    logic    peak_valid;
    logic    sequence_end;
    logic    index_overflow;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/peak_picker_min_separation_top.sv
// Top level of the peak picker with minimum separation; needs ppms_pkg for widths and structs.
// A result is registered into the output queue and offered on out_valid at the queue head.
// One sample per cycle while in_stall is low; the peak decision is one compare stage on the
// sample registers, and results leave through a three-entry output queue.
// in_stall rises while two or more results wait in that queue.
// Reset (rst_n low, synchronous): sequence state and queue cleared, min_separation = 1.
`default_nettype none

module peak_picker_min_separation_top
  import ppms_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  // sample channel
  input  wire               in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  wire               out_stall,
  output out_item_t         out_data,
  // configuration port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [ADDR_W-1:0]  paddr,
  input  wire [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int QDEPTH = 3;
  localparam int CNT_W  = 2;
  localparam int SUM_W  = ((INDEX_W > SEP_W) ? INDEX_W : SEP_W) + 1;
  localparam index_t IMAX = '1;

  // configuration
  sep_t min_sep_r;

  // sequence state
  sample_t prev_r;
  sample_t older_r;
  index_t  pos_r;
  logic    ovf_r;
  logic    pend_r;
  index_t  pend_pos_r;
  sample_t pend_lvl_r;

  sample_t prev_nxt;
  sample_t older_nxt;
  index_t  pos_nxt;
  logic    ovf_nxt;
  logic    pend_nxt;
  index_t  pend_pos_nxt;
  sample_t pend_lvl_nxt;

  // output queue, entry 0 is the head
  out_item_t        q_r   [QDEPTH];
  out_item_t        q_nxt [QDEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic      in_acc;
  logic      out_acc;
  logic      is_peak;
  index_t    cand;
  logic      far;
  logic      push_out;
  out_item_t push_res;
  out_item_t end_res;
  out_item_t res0;
  out_item_t res1;
  logic [CNT_W-1:0] cnt_pop;
  logic [CNT_W-1:0] n_push;
  out_item_t shifted [QDEPTH];
  logic [SUM_W-1:0] sep_lim;
  logic      cfg_wr;

  assign pready   = 1'b1;
  assign prdata   = DATA_W'(min_sep_r);
  assign cfg_wr   = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MIN_SEPARATION);

  assign in_stall  = (cnt_r > CNT_W'(1));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[0];
  assign out_acc   = out_valid && !out_stall;

  // peak decision on the sample held in prev_r
  always_comb begin
    is_peak = (pos_r >= INDEX_W'(2)) && (prev_r > older_r) && (prev_r > in_data.sample);
    cand    = (pos_r == IMAX && ovf_r) ? IMAX : pos_r - INDEX_W'(1);
    sep_lim = SUM_W'(pend_pos_r) + SUM_W'(min_sep_r);
    far     = SUM_W'(cand) > sep_lim;
  end

  always_comb begin
    prev_nxt     = prev_r;
    older_nxt    = older_r;
    pos_nxt      = pos_r;
    ovf_nxt      = ovf_r;
    pend_nxt     = pend_r;
    pend_pos_nxt = pend_pos_r;
    pend_lvl_nxt = pend_lvl_r;
    push_out     = 1'b0;

    push_res.peak_index     = pend_pos_r;
    push_res.peak_value     = pend_lvl_r;
    push_res.peak_valid     = 1'b1;
    push_res.sequence_end   = 1'b0;
    push_res.index_overflow = 1'b0;

    if (in_acc) begin
      if (is_peak) begin
        if (!pend_r || far) begin
          push_out     = pend_r;
          pend_nxt     = 1'b1;
          pend_pos_nxt = cand;
          pend_lvl_nxt = prev_r;
        end else if (prev_r > pend_lvl_r) begin
          pend_pos_nxt = cand;
          pend_lvl_nxt = prev_r;
        end
      end
      if (pos_r != IMAX) begin
        pos_nxt = pos_r + INDEX_W'(1);
      end else if (!in_data.last_sample) begin
        ovf_nxt = 1'b1;
      end
      older_nxt = prev_r;
      prev_nxt  = in_data.sample;
    end

    // end result reflects the pending peak after this sample
    end_res.peak_index     = pend_nxt ? pend_pos_nxt : '0;
    end_res.peak_value     = pend_nxt ? pend_lvl_nxt : '0;
    end_res.peak_valid     = pend_nxt;
    end_res.sequence_end   = 1'b1;
    end_res.index_overflow = ovf_nxt;

    if (in_acc && in_data.last_sample) begin
      prev_nxt     = '0;
      older_nxt    = '0;
      pos_nxt      = '0;
      ovf_nxt      = 1'b0;
      pend_nxt     = 1'b0;
      pend_pos_nxt = '0;
      pend_lvl_nxt = '0;
    end
  end

  // queue: pop the head, then append up to two results
  always_comb begin
    res0    = push_out ? push_res : end_res;
    res1    = end_res;
    n_push  = in_acc ? (CNT_W'(push_out) + CNT_W'(in_data.last_sample)) : '0;
    cnt_pop = cnt_r - CNT_W'(out_acc);
    for (int i = 0; i < QDEPTH; i++) begin
      shifted[i] = (out_acc && i < QDEPTH - 1) ? q_r[(i + 1) % QDEPTH] : q_r[i];
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (CNT_W'(i) < cnt_pop) begin
        q_nxt[i] = shifted[i];
      end else if (CNT_W'(i) == cnt_pop) begin
        q_nxt[i] = res0;
      end else begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_pop + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sep_r  <= MIN_SEP_RESET;
      prev_r     <= '0;
      older_r    <= '0;
      pos_r      <= '0;
      ovf_r      <= 1'b0;
      pend_r     <= 1'b0;
      pend_pos_r <= '0;
      pend_lvl_r <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_wr) begin
        min_sep_r <= pwdata[SEP_W-1:0];
      end
      prev_r     <= prev_nxt;
      older_r    <= older_nxt;
      pos_r      <= pos_nxt;
      ovf_r      <= ovf_nxt;
      pend_r     <= pend_nxt;
      pend_pos_r <= pend_pos_nxt;
      pend_lvl_r <= pend_lvl_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH))
    else $error("output queue count beyond depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_sample |=> pos_r == '0 && !pend_r && !ovf_r)
    else $error("sequence state not cleared after last sample");

  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_sample |=> cnt_r != '0)
    else $error("end result missing from output queue");

  a_ovf_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_overflow |-> out_data.sequence_end)
    else $error("overflow flag on a result that is not the end result");

endmodule

`default_nettype wire
